>>> rtl/core/ipch_pkg.sv
package ipch_pkg;

	localparam int unsigned BUFFER_ENTRIES = 128;
	localparam int unsigned TIMER_W        = 16;
	localparam int unsigned COUNT_W        = 8;
	localparam int unsigned INDEX_W        = 7;
	localparam int unsigned HASH_W         = 32;
	localparam int unsigned CFG_DATA_W     = 16;
	localparam int unsigned CFG_INDEX_W    = 1;

	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_MARK  = 2'd1;
	localparam logic [1:0] MODE_SPACE = 2'd2;
	localparam logic [1:0] MODE_STOP  = 2'd3;

	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_RESUME = 1'b1;

	localparam logic [CFG_INDEX_W-1:0] REG_GAP_LEN      = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BLINK_ENABLE = 1'd1;

	localparam logic [TIMER_W-1:0] GAP_LEN_RESET   = 16'd100;
	localparam logic [HASH_W-1:0]  HASH_BASIS      = 32'd2166136261;
	localparam logic [COUNT_W-1:0] READY_MIN       = 8'd6;
	localparam logic [COUNT_W-1:0] BUF_LIMIT       = COUNT_W'(BUFFER_ENTRIES);

	localparam logic [1:0] CMP_SHORTER = 2'd0;
	localparam logic [1:0] CMP_SAME    = 2'd1;
	localparam logic [1:0] CMP_LONGER  = 2'd2;

	// FNV prime 16777619 = 2^24 + 256 + 128 + 16 + 2 + 1, product mod 2^32
	function automatic logic [HASH_W-1:0] fnv_mul(input logic [HASH_W-1:0] h);
		return (h << 24) + (h << 8) + (h << 7) + (h << 4) + (h << 1) + h;
	endfunction

	// 20 percent tolerance: shorter when 5*new < 4*old, longer when 5*old < 4*new
	function automatic logic [1:0] cmp_widths(input logic [TIMER_W-1:0] oldv,
		input logic [TIMER_W-1:0] newv);
		logic [TIMER_W+2:0] n5, o5, n4, o4;
		n5 = {1'b0, newv, 2'b00} + {3'b000, newv};
		o5 = {1'b0, oldv, 2'b00} + {3'b000, oldv};
		n4 = {1'b0, newv, 2'b00};
		o4 = {1'b0, oldv, 2'b00};
		if (n5 < o4)
			return CMP_SHORTER;
		else if (o5 < n4)
			return CMP_LONGER;
		else
			return CMP_SAME;
	endfunction

endpackage

>>> rtl/core/ir_pulse_capture_hash.sv
// IR pulse-width capture with a running width-compare hash. Each input beat
// is either one sampled receiver tick (command 0, level 1 = mark) or a resume
// (command 1). The block times alternating mark and space widths, starts a
// frame after an idle gap of at least gap_len, ends it on a space longer
// than gap_len or when the entry buffer limit is hit, and reports every
// recorded width with its index. Entries from index 3 on are compared with
// the entry two back (20 percent tolerance) and the result is folded into a
// 32-bit FNV-1 hash. Exactly one result beat leaves for every input beat.
// Rate: one beat per cycle while out_ready stays high; each beat passes the
// input register, then the result register. The per-tick state loop (timer,
// count, width history, hash) closes combinationally through the constant
// FNV multiply, which is a shift-and-add tree. Write gap_len and blink_enable
// only while no beats are in flight.
module ir_pulse_capture_hash (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// config write port
	input  logic                                 cfg_we,
	input  logic [ipch_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [ipch_pkg::CFG_DATA_W-1:0]      cfg_data,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 command,
	input  logic                                 level,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [1:0]                           capture_state,
	output logic                                 width_valid,
	output logic [ipch_pkg::TIMER_W-1:0]         width,
	output logic [ipch_pkg::INDEX_W-1:0]         width_index,
	output logic [ipch_pkg::COUNT_W-1:0]         entry_count,
	output logic                                 code_ready,
	output logic [ipch_pkg::HASH_W-1:0]          code_hash,
	output logic                                 led_on
);
	import ipch_pkg::*;

	// config registers
	logic [TIMER_W-1:0] gap_len_q;
	logic               blink_enable_q;

	// capture state
	logic [1:0]         mode_q;
	logic [TIMER_W-1:0] timer_q;
	logic [COUNT_W-1:0] count_q;
	logic [TIMER_W-1:0] two_back_q;
	logic [TIMER_W-1:0] one_back_q;
	logic [HASH_W-1:0]  hash_q;
	logic               led_q;

	// input stage
	logic valid_s1;
	logic command_s1;
	logic level_s1;

	// result register
	logic               out_valid_q;
	logic [1:0]         state_s2;
	logic               wvalid_s2;
	logic [TIMER_W-1:0] width_s2;
	logic [INDEX_W-1:0] index_s2;
	logic [COUNT_W-1:0] count_s2;
	logic               ready_s2;
	logic [HASH_W-1:0]  hash_s2;
	logic               led_s2;

	logic advance;

	// result slot free or being drained this cycle
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_len_q      <= GAP_LEN_RESET;
			blink_enable_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAP_LEN:      gap_len_q      <= cfg_data;
				REG_BLINK_ENABLE: blink_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			command_s1 <= command;
			level_s1   <= level;
		end
	end

	// next-state and result for the beat in the input stage
	logic [1:0]         mode_d;
	logic [TIMER_W-1:0] timer_d;
	logic [COUNT_W-1:0] count_d;
	logic [TIMER_W-1:0] two_back_d;
	logic [TIMER_W-1:0] one_back_d;
	logic [HASH_W-1:0]  hash_d;
	logic               led_d;
	logic               rec;
	logic [TIMER_W-1:0] timer_inc;
	logic [1:0]         mode_eff;
	logic               frame_start;
	logic [COUNT_W-1:0] rec_count;
	logic [TIMER_W-1:0] rec_one_back;
	logic [HASH_W-1:0]  rec_hash;

	assign timer_inc = timer_q + TIMER_W'(1);
	assign mode_eff  = (count_q >= BUF_LIMIT) ? MODE_STOP : mode_q;

	always_comb begin
		mode_d      = mode_q;
		timer_d     = timer_q;
		count_d     = count_q;
		two_back_d  = two_back_q;
		one_back_d  = one_back_q;
		hash_d      = hash_q;
		led_d       = led_q;
		rec         = 1'b0;
		frame_start = 1'b0;

		if (command_s1 == CMD_RESUME) begin
			mode_d     = MODE_IDLE;
			count_d    = '0;
			two_back_d = '0;
			one_back_d = '0;
			hash_d     = HASH_BASIS;
		end else begin
			timer_d = timer_inc;
			mode_d  = mode_eff;
			case (mode_eff)
				MODE_IDLE: begin
					if (level_s1) begin
						timer_d = '0;
						if (timer_inc >= gap_len_q) begin
							rec         = 1'b1;
							frame_start = 1'b1;
							mode_d      = MODE_MARK;
						end
					end
				end
				MODE_MARK: begin
					if (!level_s1) begin
						rec     = 1'b1;
						timer_d = '0;
						mode_d  = MODE_SPACE;
					end
				end
				MODE_SPACE: begin
					if (level_s1) begin
						rec     = 1'b1;
						timer_d = '0;
						mode_d  = MODE_MARK;
					end else if (timer_inc > gap_len_q) begin
						mode_d = MODE_STOP;
					end
				end
				default: begin
					if (level_s1)
						timer_d = '0;
				end
			endcase
			if (blink_enable_q)
				led_d = level_s1;
		end

		// frame start wipes the history before entry 0 goes in
		rec_count    = frame_start ? '0 : count_q;
		rec_one_back = frame_start ? '0 : one_back_q;
		rec_hash     = frame_start ? HASH_BASIS : hash_q;
		if (rec) begin
			count_d    = rec_count + COUNT_W'(1);
			two_back_d = rec_one_back;
			one_back_d = timer_inc;
			hash_d     = (rec_count >= 8'd3)
				? (fnv_mul(rec_hash) ^ {30'd0, cmp_widths(two_back_q, timer_inc)})
				: rec_hash;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			timer_q    <= '0;
			count_q    <= '0;
			two_back_q <= '0;
			one_back_q <= '0;
			hash_q     <= HASH_BASIS;
			led_q      <= 1'b0;
		end else if (valid_s1 && advance) begin
			mode_q     <= mode_d;
			timer_q    <= timer_d;
			count_q    <= count_d;
			two_back_q <= two_back_d;
			one_back_q <= one_back_d;
			hash_q     <= hash_d;
			led_q      <= led_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			state_s2  <= mode_d;
			wvalid_s2 <= rec;
			width_s2  <= rec ? timer_inc : '0;
			index_s2  <= rec ? rec_count[INDEX_W-1:0] : '0;
			count_s2  <= count_d;
			ready_s2  <= (mode_d == MODE_STOP) && (count_d >= READY_MIN);
			hash_s2   <= hash_d;
			led_s2    <= led_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign capture_state = state_s2;
	assign width_valid   = wvalid_s2;
	assign width         = width_s2;
	assign width_index   = index_s2;
	assign entry_count   = count_s2;
	assign code_ready    = ready_s2;
	assign code_hash     = hash_s2;
	assign led_on        = led_s2;

endmodule
